// ===== hdl/dcd_pkg.sv =====
package dcd_pkg;

   localparam int PIX_W     = 8;
   localparam int RATIO_W   = 16;
   localparam int DEN_W     = 24;
   localparam int PROD_W    = RATIO_W + PIX_W;
   localparam int NUM_LANES = 3;
   localparam int QUOT_BITS = 8;
   localparam int NUM_W     = 33;

   localparam logic [DEN_W-1:0] FULL_SCALE = 24'd16711680;
   localparam logic [DEN_W-1:0] DEN_FLOOR  = 24'd1671168;

   localparam int FRONT_LAT = 3;
   localparam int LANE_LAT  = QUOT_BITS + 1;
   localparam int TOTAL_LAT = FRONT_LAT + LANE_LAT + 1;

   typedef logic [PIX_W-1:0] chan_type;

   typedef struct packed {
      logic [NUM_LANES-1:0][PIX_W-1:0] colour;
      chan_type                        alpha;
      logic                            frame_end;
   } pixel_type;

   typedef struct packed {
      logic             valid;
      logic [DEN_W-1:0] den;
      pixel_type        pix;
   } front_type;

   typedef struct packed {
      chan_type alpha;
      logic     frame_end;
   } side_type;

endpackage

// ===== hdl/dcd_front.sv =====
module dcd_front import dcd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  pixel_type          pix_in,
   input  logic [RATIO_W-1:0] ratio,
   output front_type          front_out
);

   logic             valid1_ff;
   pixel_type        pix1_ff;
   logic             valid2_ff;
   pixel_type        pix2_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;
   logic             valid3_ff;
   pixel_type        pix3_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W-1:0] den_in;
   chan_type         dark;
   chan_type         dark_rg;

   always_comb begin
      dark_rg = (pix1_ff.colour[1] < pix1_ff.colour[0]) ? pix1_ff.colour[1]
                                                         : pix1_ff.colour[0];
      dark    = (pix1_ff.colour[2] < dark_rg) ? pix1_ff.colour[2] : dark_rg;
      prod_in = PROD_W'(ratio) * PROD_W'(dark);
   end

   always_comb begin
      den_in = FULL_SCALE - DEN_W'(prod_ff);
      if (den_in < DEN_FLOOR) begin
         den_in = DEN_FLOOR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         valid1_ff <= accept;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pix1_ff <= pix_in;
      end
      pix2_ff <= pix1_ff;
      prod_ff <= prod_in;
      pix3_ff <= pix2_ff;
      den_ff  <= den_in;
   end

   assign front_out.valid = valid3_ff;
   assign front_out.den   = den_ff;
   assign front_out.pix   = pix3_ff;

endmodule

// ===== hdl/dcd_lane.sv =====
module dcd_lane import dcd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             valid_in,
   input  logic [DEN_W-1:0] den_in,
   input  chan_type         chan_in,
   output logic             valid_out,
   output chan_type         value_out
);

   logic                 valid_ff [0:QUOT_BITS];
   logic [NUM_W-1:0]     rem_ff   [0:QUOT_BITS];
   logic [DEN_W-1:0]     den_ff   [0:QUOT_BITS];
   logic [QUOT_BITS-1:0] quot_ff  [0:QUOT_BITS];
   logic                 ovf_ff   [0:QUOT_BITS];

   chan_type         inv;
   logic [15:0]      scaled;
   logic [31:0]      num;
   logic [31:0]      limit;
   logic             ovf_in;
   logic [NUM_W-1:0] dividend_in;

   always_comb begin
      inv         = 8'd255 - chan_in;
      scaled      = {inv, 8'b0} - 16'(inv);
      num         = {scaled, 16'b0};
      limit       = {den_in, 8'b0} - 32'({den_in, 1'b0});
      ovf_in      = num > limit;
      dividend_in = NUM_W'(num) + NUM_W'(den_in) - NUM_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0]  <= dividend_in;
      den_ff[0]  <= den_in;
      quot_ff[0] <= '0;
      ovf_ff[0]  <= ovf_in;
   end

   for (genvar k = 0; k < QUOT_BITS; k++) begin : g_step
      logic [NUM_W-1:0]     dsh;
      logic [NUM_W-1:0]     rem_in;
      logic [QUOT_BITS-1:0] quot_in;

      always_comb begin
         dsh = NUM_W'(den_ff[k]) << (QUOT_BITS - 1 - k);
         if (rem_ff[k] >= dsh) begin
            rem_in  = rem_ff[k] - dsh;
            quot_in = quot_ff[k] | (QUOT_BITS'(1) << (QUOT_BITS - 1 - k));
         end else begin
            rem_in  = rem_ff[k];
            quot_in = quot_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else begin
            valid_ff[k+1] <= valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k+1]  <= rem_in;
         den_ff[k+1]  <= den_ff[k];
         quot_ff[k+1] <= quot_in;
         ovf_ff[k+1]  <= ovf_ff[k];
      end
   end

   assign valid_out = valid_ff[QUOT_BITS];
   assign value_out = ovf_ff[QUOT_BITS] ? '0 : 8'd255 - quot_ff[QUOT_BITS];

endmodule

// ===== hdl/dark_channel_dehaze_pixel_top.sv =====
// Channel   Direction  Handshake                 Payload
// request   in         start, busy               req_red_in .. req_frame_end_in
// response  out        rsp_valid (strobe)        rsp_red_out .. rsp_frame_end_out
// csr       in         csr_valid, csr_ready      csr_dehaze_ratio
//
// One pixel is accepted every clock cycle; busy never rises.
// Each request passes the front end, which forms the dark value and the denominator (pixel,
// product and denominator registers), then the per-channel restoring divider (a set-up stage,
// then eight stages of one quotient bit each), then the output register.
// Synchronous reset empties the pipeline and clears the ratio register.
// Results are shown for exactly one cycle; the receiver cannot stall them.
module dark_channel_dehaze_pixel_top import dcd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [7:0]         req_red_in,
   input  logic [7:0]         req_green_in,
   input  logic [7:0]         req_blue_in,
   input  logic [7:0]         req_alpha_in,
   input  logic               req_frame_end_in,
   output logic               rsp_valid,
   output logic [7:0]         rsp_red_out,
   output logic [7:0]         rsp_green_out,
   output logic [7:0]         rsp_blue_out,
   output logic [7:0]         rsp_alpha_out,
   output logic               rsp_frame_end_out,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [RATIO_W-1:0] csr_dehaze_ratio
);

   logic [RATIO_W-1:0]              ratio_ff;
   logic                            accept;
   pixel_type                       pix_in;
   front_type                       front;
   logic [NUM_LANES-1:0]            lane_valid;
   logic [NUM_LANES-1:0][PIX_W-1:0] lane_value;
   side_type                        side_ff [0:LANE_LAT-1];
   logic                            rsp_valid_ff;
   logic [NUM_LANES-1:0][PIX_W-1:0] rsp_colour_ff;
   side_type                        rsp_side_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         ratio_ff <= csr_dehaze_ratio;
      end
   end

   assign pix_in.colour[0] = req_red_in;
   assign pix_in.colour[1] = req_green_in;
   assign pix_in.colour[2] = req_blue_in;
   assign pix_in.alpha     = req_alpha_in;
   assign pix_in.frame_end = req_frame_end_in;

   dcd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .pix_in    (pix_in),
      .ratio     (ratio_ff),
      .front_out (front)
   );

   for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
      dcd_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .valid_in  (front.valid),
         .den_in    (front.den),
         .chan_in   (front.pix.colour[i]),
         .valid_out (lane_valid[i]),
         .value_out (lane_value[i])
      );
   end

   always_ff @(posedge clock) begin
      side_ff[0].alpha     <= front.pix.alpha;
      side_ff[0].frame_end <= front.pix.frame_end;
      for (int k = 1; k < LANE_LAT; k++) begin
         side_ff[k] <= side_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= lane_valid[0];
      end
   end

   always_ff @(posedge clock) begin
      rsp_colour_ff <= lane_value;
      rsp_side_ff   <= side_ff[LANE_LAT-1];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_red_out       = rsp_colour_ff[0];
   assign rsp_green_out     = rsp_colour_ff[1];
   assign rsp_blue_out      = rsp_colour_ff[2];
   assign rsp_alpha_out     = rsp_side_ff.alpha;
   assign rsp_frame_end_out = rsp_side_ff.frame_end;

   // All colour lanes must advance in lock step.
   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      (lane_valid == '0) || (lane_valid == '1))
      else $error("colour lanes out of step");

   // Every response stems from a transaction accepted a fixed latency earlier.
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, TOTAL_LAT))
      else $error("response without matching request");

   // Alpha travels alongside the divider with the same delay.
   a_alpha_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_alpha_out == $past(req_alpha_in, TOTAL_LAT)))
      else $error("alpha misaligned with colour result");

endmodule
